// File: rtl/tcf_pkg.sv
// Package for the tilt complementary filter: widths, register map,
// reset values, CORDIC arctangent table and saturation helper.
// No dependencies.
package tcf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 16;
    localparam int DIV_STEPS    = 56;

    localparam int ANG_W   = 17;
    localparam int XY_W    = 44;
    localparam int Z_W     = 26;
    localparam int MUL_A_W = 38;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = 56;
    localparam int DEN_W   = 36;
    localparam int REM_W   = DEN_W + 1;
    localparam int CNT_W   = 6;
    localparam int ADDR_W  = 4;

    typedef logic signed [ANG_W-1:0] angle_t;

    localparam logic [1:0] REG_GYRO_CPD      = 2'd0;
    localparam logic [1:0] REG_BLEND_WEIGHT  = 2'd1;
    localparam logic [1:0] REG_MAX_GAP       = 2'd2;
    localparam logic [1:0] REG_DEFAULT_STEP  = 2'd3;

    localparam logic [15:0] CPD_RESET        = 16'd131;
    localparam logic [16:0] WEIGHT_RESET     = 17'd64225;
    localparam logic [31:0] MAX_GAP_RESET    = 32'd200000;
    localparam logic [19:0] DEF_STEP_RESET   = 20'd10000;

    localparam logic [16:0] WEIGHT_ONE       = 17'h10000;
    localparam logic signed [MUL_A_W-1:0] US_PER_S = 38'sd1000000;
    localparam logic signed [Z_W-1:0] QUARTER_TURN = 26'sd5898240;

    // atan(2^-i) in 1/65536 degree, rounded
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

    function automatic angle_t sat17(input logic signed [39:0] v);
        angle_t r;
        if (v > 40'sd65535)
            r = 17'sd65535;
        else if (v < -40'sd65536)
            r = -17'sd65536;
        else
            r = v[ANG_W-1:0];
        return r;
    endfunction

endpackage

// File: rtl/tcf_sample_if.sv
// Input channel of the tilt filter: one raw IMU sample per beat.
// Depends on nothing.
interface tcf_sample_if;
    logic               valid;
    logic               ready;
    logic               restart;
    logic [31:0]        time_us;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;

    modport source (output valid, restart, time_us, accel_x, accel_y, accel_z,
                    gyro_x, gyro_y, input ready);
    modport sink   (input valid, restart, time_us, accel_x, accel_y, accel_z,
                    gyro_x, gyro_y, output ready);
endinterface

// File: rtl/tcf_result_if.sv
// Output channel of the tilt filter: pitch and roll per beat.
// Depends on nothing.
interface tcf_result_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pitch_angle;
    logic signed [16:0] roll_angle;

    modport source (output valid, pitch_angle, roll_angle, input ready);
    modport sink   (input valid, pitch_angle, roll_angle, output ready);
endinterface

// File: rtl/tilt_complementary_filter.sv
// Tilt complementary filter top level: sequencer around one shared multiplier,
// CORDIC step, square root step and divider step.
// Depends on tcf_pkg, tcf_sample_if, tcf_result_if.
//
// Usage:
//   sample (valid/ready): one raw IMU sample per beat. ready is high only while
//   the sequencer is idle; each sample is worked through alone.
//   result (valid/ready): one pitch/roll beat per sample, held in an output
//   register so the next sample may be taken while a result waits.
//   APB port: four registers at byte offsets 0, 4, 8, 12 (gyro scale, blend
//   weight, max gap, default step); write only while idle, pready tied high.
// Sequence, accept to result valid:
//   seeding sample (first after reset or restart): two squares, 16 root
//     steps, a CORDIC pass for pitch and one for roll, then the seed decision.
//   blended sample: the same steps, then scaling, division and blending
//     per angle; the restoring divider, once for pitch and once for roll,
//     dominates. The sequencer returns to idle before the next sample.
// Reset: configuration takes its defaults, angles and timestamp clear and the
//   filter is unseeded. A stalled result receiver holds the finished beat in
//   the output register; the sequencer waits in its last state until it drains.
module tilt_complementary_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcf_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    tcf_sample_if.sink                    sample,
    tcf_result_if.source                  result
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ1   = 4'd1;
    localparam logic [3:0] S_SQ2   = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_CINIT = 4'd4;
    localparam logic [3:0] S_CITER = 4'd5;
    localparam logic [3:0] S_CDONE = 4'd6;
    localparam logic [3:0] S_DT    = 4'd7;
    localparam logic [3:0] S_NUM   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_W1    = 4'd10;
    localparam logic [3:0] S_W2    = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    localparam int XY_W = tcf_pkg::XY_W;
    localparam int Z_W  = tcf_pkg::Z_W;
    localparam int PW   = tcf_pkg::PROD_W;

    // Configuration registers
    logic [15:0] cpd_reg, cpd_next;
    logic [16:0] weight_reg, weight_next;
    logic [31:0] max_gap_reg, max_gap_next;
    logic [19:0] def_step_reg, def_step_next;

    // Control state
    logic [3:0]                  state_reg, state_next;
    logic [tcf_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        pass_reg, pass_next;
    logic                        seeded_reg, seeded_next;
    logic                        out_valid_reg, out_valid_next;

    // Filter state
    tcf_pkg::angle_t             pitch_st_reg, pitch_st_next;
    tcf_pkg::angle_t             roll_st_reg, roll_st_next;
    logic [31:0]                 last_time_reg, last_time_next;

    // Latched sample
    logic                        restart_reg, restart_next;
    logic [31:0]                 time_reg, time_next;
    logic signed [15:0]          ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [15:0]          gx_reg, gx_next, gy_reg, gy_next;

    // Datapath registers
    logic signed [PW-1:0]        acc_reg, acc_next;
    logic [31:0]                 rad_reg, rad_next;
    logic [31:0]                 root_reg, root_next;
    logic [31:0]                 bit_reg, bit_next;
    logic signed [XY_W-1:0]      cx_reg, cx_next, cy_reg, cy_next;
    logic signed [Z_W-1:0]       cz_reg, cz_next;
    tcf_pkg::angle_t             pacc_reg, pacc_next, racc_reg, racc_next;
    logic [31:0]                 dt_reg, dt_next;
    logic [tcf_pkg::DEN_W-1:0]   den_reg, den_next;
    logic [PW-1:0]               div_reg, div_next;
    logic [tcf_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic                        neg_reg, neg_next;
    tcf_pkg::angle_t             out_pitch_reg, out_pitch_next;
    tcf_pkg::angle_t             out_roll_reg, out_roll_next;

    // Shared multiplier
    logic signed [tcf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tcf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]               mul_p;

    // Helpers
    logic                        cfg_wr;
    logic [15:0]                 cpd_eff;
    logic [16:0]                 w_eff;
    logic [31:0]                 dt_raw;
    logic signed [tcf_pkg::MUL_A_W-1:0] q_s, delta_s, v_s;
    tcf_pkg::angle_t             old_ang, acc_ang;
    logic signed [15:0]          g_sel;
    logic [32:0]                 sq_trial;
    logic signed [16:0]          cy0, cx0;
    logic signed [XY_W-1:0]      ys0, xs0, xsh, ysh;
    logic signed [Z_W-1:0]       z_rnd;
    tcf_pkg::angle_t             conv_ang;
    logic [tcf_pkg::REM_W-1:0]   rem_sh;
    logic [PW-1:0]               mag;
    logic signed [PW-1:0]        fin_sum;
    tcf_pkg::angle_t             fin_ang;
    logic                        out_load;

    assign pready       = 1'b1;
    assign cfg_wr       = psel & penable & pwrite;
    assign sample.ready = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.pitch_angle = out_pitch_reg;
    assign result.roll_angle  = out_roll_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            tcf_pkg::REG_GYRO_CPD:     prdata = {16'd0, cpd_reg};
            tcf_pkg::REG_BLEND_WEIGHT: prdata = {15'd0, weight_reg};
            tcf_pkg::REG_MAX_GAP:      prdata = max_gap_reg;
            tcf_pkg::REG_DEFAULT_STEP: prdata = {12'd0, def_step_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Clamp configuration: zero scale counts as one, weight tops out at one
    assign cpd_eff = (cpd_reg == 16'd0) ? 16'd1 : cpd_reg;
    assign w_eff   = (weight_reg > tcf_pkg::WEIGHT_ONE) ? tcf_pkg::WEIGHT_ONE : weight_reg;
    assign dt_raw  = time_reg - last_time_reg;

    assign old_ang = pass_reg ? roll_st_reg : pitch_st_reg;
    assign acc_ang = pass_reg ? racc_reg : pacc_reg;
    assign g_sel   = pass_reg ? gx_reg : gy_reg;

    // Signed gyro delta from the divider quotient
    assign q_s     = {1'b0, div_reg[36:0]};
    assign delta_s = neg_reg ? -q_s : q_s;
    assign v_s     = delta_s + tcf_pkg::MUL_A_W'(old_ang);

    always_comb
    begin
        unique case (state_reg)
            S_SQ1:
            begin
                mul_a = tcf_pkg::MUL_A_W'(ay_reg);
                mul_b = tcf_pkg::MUL_B_W'(ay_reg);
            end
            S_SQ2:
            begin
                mul_a = tcf_pkg::MUL_A_W'(az_reg);
                mul_b = tcf_pkg::MUL_B_W'(az_reg);
            end
            S_DT:
            begin
                mul_a = tcf_pkg::US_PER_S;
                mul_b = {2'b00, cpd_eff};
            end
            S_NUM:
            begin
                mul_a = {6'd0, dt_reg};
                mul_b = tcf_pkg::MUL_B_W'(g_sel);
            end
            S_W1:
            begin
                mul_a = v_s;
                mul_b = {1'b0, w_eff};
            end
            S_W2:
            begin
                mul_a = tcf_pkg::MUL_A_W'(acc_ang);
                mul_b = {1'b0, tcf_pkg::WEIGHT_ONE - w_eff};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Square root step
    assign sq_trial = {1'b0, root_reg} + {1'b0, bit_reg};

    // CORDIC set-up: pitch uses (-ax, root), roll uses (ay, az)
    assign cy0 = pass_reg ? 17'(ay_reg) : -17'(ax_reg);
    assign cx0 = pass_reg ? 17'(az_reg) : {1'b0, root_reg[15:0]};
    assign ys0 = XY_W'(cy0) <<< 24;
    assign xs0 = XY_W'(cx0) <<< 24;
    assign xsh = cx_reg >>> cnt_reg[4:0];
    assign ysh = cy_reg >>> cnt_reg[4:0];
    assign z_rnd    = cz_reg + Z_W'(128);
    assign conv_ang = tcf_pkg::sat17(40'(z_rnd >>> 8));

    // Divider step
    assign rem_sh = {rem_reg[tcf_pkg::REM_W-2:0], div_reg[PW-1]};
    assign mag    = mul_p[PW-1] ? PW'(-mul_p) : PW'(mul_p);

    // Blend rounding
    assign fin_sum = acc_reg + PW'(32768);
    assign fin_ang = tcf_pkg::sat17(40'(fin_sum >>> 16));

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        cpd_next      = cpd_reg;
        weight_next   = weight_reg;
        max_gap_next  = max_gap_reg;
        def_step_next = def_step_reg;
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pass_next     = pass_reg;
        seeded_next   = seeded_reg;
        pitch_st_next = pitch_st_reg;
        roll_st_next  = roll_st_reg;
        last_time_next = last_time_reg;
        restart_next  = restart_reg;
        time_next     = time_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        az_next       = az_reg;
        gx_next       = gx_reg;
        gy_next       = gy_reg;
        acc_next      = acc_reg;
        rad_next      = rad_reg;
        root_next     = root_reg;
        bit_next      = bit_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        pacc_next     = pacc_reg;
        racc_next     = racc_reg;
        dt_next       = dt_reg;
        den_next      = den_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        out_pitch_next = out_pitch_reg;
        out_roll_next  = out_roll_reg;

        // Drop the waiting beat once taken
        out_valid_next = out_valid_reg && !result.ready;

        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                tcf_pkg::REG_GYRO_CPD:     cpd_next      = pwdata[15:0];
                tcf_pkg::REG_BLEND_WEIGHT: weight_next   = pwdata[16:0];
                tcf_pkg::REG_MAX_GAP:      max_gap_next  = pwdata;
                tcf_pkg::REG_DEFAULT_STEP: def_step_next = pwdata[19:0];
                default:                   cpd_next      = cpd_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    restart_next = sample.restart;
                    time_next    = sample.time_us;
                    ax_next      = sample.accel_x;
                    ay_next      = sample.accel_y;
                    az_next      = sample.accel_z;
                    gx_next      = sample.gyro_x;
                    gy_next      = sample.gyro_y;
                    state_next   = S_SQ1;
                end
            end
            S_SQ1:
            begin
                acc_next   = mul_p;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                rad_next   = acc_reg[31:0] + mul_p[31:0];
                root_next  = 32'd0;
                bit_next   = 32'h4000_0000;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if ({1'b0, rad_reg} >= sq_trial)
                begin
                    rad_next  = rad_reg - sq_trial[31:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tcf_pkg::CNT_W'(tcf_pkg::SQRT_STEPS - 1))
                begin
                    pass_next  = 1'b0;
                    state_next = S_CINIT;
                end
            end
            S_CINIT:
            begin
                cnt_next = '0;
                if (cx0 == 17'sd0 && cy0 == 17'sd0)
                begin
                    // Zero vector reads as angle zero
                    cz_next    = '0;
                    state_next = S_CDONE;
                end
                else
                begin
                    state_next = S_CITER;
                    if (cx0 < 17'sd0)
                    begin
                        if (cy0 >= 17'sd0)
                        begin
                            cx_next = ys0;
                            cy_next = -xs0;
                            cz_next = tcf_pkg::QUARTER_TURN;
                        end
                        else
                        begin
                            cx_next = -ys0;
                            cy_next = xs0;
                            cz_next = -tcf_pkg::QUARTER_TURN;
                        end
                    end
                    else
                    begin
                        cx_next = xs0;
                        cy_next = ys0;
                        cz_next = '0;
                    end
                end
            end
            S_CITER:
            begin
                if (cy_reg > 0)
                begin
                    cx_next = cx_reg + ysh;
                    cy_next = cy_reg - xsh;
                    cz_next = cz_reg + tcf_pkg::atan_entry(cnt_reg[4:0]);
                end
                else
                begin
                    cx_next = cx_reg - ysh;
                    cy_next = cy_reg + xsh;
                    cz_next = cz_reg - tcf_pkg::atan_entry(cnt_reg[4:0]);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tcf_pkg::CNT_W'(tcf_pkg::CORDIC_STEPS - 1))
                    state_next = S_CDONE;
            end
            S_CDONE:
            begin
                if (!pass_reg)
                begin
                    pacc_next  = conv_ang;
                    pass_next  = 1'b1;
                    state_next = S_CINIT;
                end
                else
                begin
                    racc_next = conv_ang;
                    pass_next = 1'b0;
                    if (restart_reg || !seeded_reg)
                    begin
                        // Seed both angles straight from the accelerometer
                        pitch_st_next = pacc_reg;
                        roll_st_next  = conv_ang;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        state_next = S_DT;
                    end
                end
            end
            S_DT:
            begin
                if (dt_raw == 32'd0 || dt_raw > max_gap_reg)
                    dt_next = {12'd0, def_step_reg};
                else
                    dt_next = dt_raw;
                den_next   = mul_p[tcf_pkg::DEN_W-1:0];
                state_next = S_NUM;
            end
            S_NUM:
            begin
                neg_next   = mul_p[PW-1];
                div_next   = (mag << 8) + PW'(den_reg >> 1);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    div_next = {div_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    div_next = {div_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tcf_pkg::CNT_W'(tcf_pkg::DIV_STEPS - 1))
                    state_next = S_W1;
            end
            S_W1:
            begin
                acc_next   = mul_p;
                state_next = S_W2;
            end
            S_W2:
            begin
                acc_next   = acc_reg + mul_p;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!pass_reg)
                begin
                    pitch_st_next = fin_ang;
                    pass_next     = 1'b1;
                    state_next    = S_NUM;
                end
                else
                begin
                    roll_st_next = fin_ang;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_pitch_next = pitch_st_reg;
                    out_roll_next  = roll_st_reg;
                    last_time_next = time_reg;
                    seeded_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpd_reg       <= tcf_pkg::CPD_RESET;
            weight_reg    <= tcf_pkg::WEIGHT_RESET;
            max_gap_reg   <= tcf_pkg::MAX_GAP_RESET;
            def_step_reg  <= tcf_pkg::DEF_STEP_RESET;
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pass_reg      <= 1'b0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pitch_st_reg  <= '0;
            roll_st_reg   <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            cpd_reg       <= cpd_next;
            weight_reg    <= weight_next;
            max_gap_reg   <= max_gap_next;
            def_step_reg  <= def_step_next;
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pass_reg      <= pass_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
            pitch_st_reg  <= pitch_st_next;
            roll_st_reg   <= roll_st_next;
            last_time_reg <= last_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        restart_reg   <= restart_next;
        time_reg      <= time_next;
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        az_reg        <= az_next;
        gx_reg        <= gx_next;
        gy_reg        <= gy_next;
        acc_reg       <= acc_next;
        rad_reg       <= rad_next;
        root_reg      <= root_next;
        bit_reg       <= bit_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cz_reg        <= cz_next;
        pacc_reg      <= pacc_next;
        racc_reg      <= racc_next;
        dt_reg        <= dt_next;
        den_reg       <= den_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        out_pitch_reg <= out_pitch_next;
        out_roll_reg  <= out_roll_next;
    end

endmodule

// File: test/tcf_checker.sv
// Scoreboard for the tilt complementary filter: watches the APB writes and both
// channels, predicts pitch and roll per accepted sample and compares results.
// Depends on tcf_pkg, tcf_sample_if and tcf_result_if.
module tcf_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [tcf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    tcf_sample_if        smp,
    tcf_result_if        res,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        tcf_pkg::angle_t pitch;
        tcf_pkg::angle_t roll;
    } tilt_pair_t;

    tilt_pair_t tilt_due[$];

    longint atan_q16 [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                              58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                              229, 115};

    logic [15:0] cpd;
    logic [16:0] weight;
    logic [31:0] max_gap;
    logic [19:0] def_step;
    logic        seeded;
    int          pitch_now;
    int          roll_now;
    logic [31:0] last_time;

    function automatic longint root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 32;
        while (b > n)
            b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic int clip17(longint v);
        if (v > 65535)
            return 65535;
        if (v < -65536)
            return -65536;
        return int'(v);
    endfunction

    // vectoring CORDIC, answer in 1/256 degree
    function automatic int tilt_atan2(longint y0, longint x0);
        longint x;
        longint y;
        longint z;
        longint t;
        longint xs;
        longint ys;
        if (x0 == 0 && y0 == 0)
            return 0;
        x = x0 * 64'sd16777216;
        y = y0 * 64'sd16777216;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = 90 * 65536;
            end else begin
                x = -y;
                y = t;
                z = -90 * 65536;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q16[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q16[i];
            end
        end
        return int'((z + 128) >>> 8);
    endfunction

    function automatic int fuse_angle(int prev, int rate, logic [31:0] dt, int acc);
        longint den;
        longint num;
        longint mag;
        longint q;
        longint delta;
        longint w;
        longint s;
        den = (cpd == 0 ? 64'sd1 : longint'(cpd)) * 64'sd1000000;
        num = longint'(rate) * longint'({32'd0, dt}) * 256;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        delta = num < 0 ? -q : q;
        w = weight > 17'd65536 ? 64'sd65536 : longint'(weight);
        s = w * (longint'(prev) + delta) + (65536 - w) * longint'(acc);
        return clip17((s + 32768) >>> 16);
    endfunction

    // track register writes at the completing access edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cpd      <= tcf_pkg::CPD_RESET;
            weight   <= tcf_pkg::WEIGHT_RESET;
            max_gap  <= tcf_pkg::MAX_GAP_RESET;
            def_step <= tcf_pkg::DEF_STEP_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                tcf_pkg::REG_GYRO_CPD:     cpd      <= pwdata[15:0];
                tcf_pkg::REG_BLEND_WEIGHT: weight   <= pwdata[16:0];
                tcf_pkg::REG_MAX_GAP:      max_gap  <= pwdata;
                default:                   def_step <= pwdata[19:0];
            endcase
        end
    end

    always @(posedge clk or negedge rst_n) begin
        tilt_pair_t  e;
        tilt_pair_t  got;
        longint      m;
        int          p_acc;
        int          r_acc;
        int          bad;
        logic [31:0] dt;
        if (!rst_n) begin
            seeded    <= 1'b0;
            pitch_now <= 0;
            roll_now  <= 0;
            last_time <= '0;
            errors    <= 0;
            tilt_due.delete();
        end else begin
            bad = 0;
            if (smp.valid && smp.ready) begin
                m = root_floor(longint'(smp.accel_y) * smp.accel_y
                               + longint'(smp.accel_z) * smp.accel_z);
                p_acc = clip17(tilt_atan2(-longint'(smp.accel_x), m));
                r_acc = clip17(tilt_atan2(smp.accel_y, smp.accel_z));
                if (smp.restart || !seeded) begin
                    e.pitch = p_acc[16:0];
                    e.roll  = r_acc[16:0];
                end else begin
                    dt = smp.time_us - last_time;
                    if (dt == 0 || dt > max_gap)
                        dt = {12'd0, def_step};
                    e.pitch = 17'(fuse_angle(pitch_now, smp.gyro_y, dt, p_acc));
                    e.roll  = 17'(fuse_angle(roll_now, smp.gyro_x, dt, r_acc));
                end
                seeded    <= 1'b1;
                pitch_now <= e.pitch;
                roll_now  <= e.roll;
                last_time <= smp.time_us;
                tilt_due.push_back(e);
            end
            if (res.valid && res.ready) begin
                got.pitch = res.pitch_angle;
                got.roll  = res.roll_angle;
                if (tilt_due.size() == 0) begin
                    $display("%0t: result beat with nothing due: pitch %0d roll %0d",
                             $time, got.pitch, got.roll);
                    bad = bad + 1;
                end else begin
                    e = tilt_due.pop_front();
                    if (got.pitch !== e.pitch) begin
                        $display("%0t: pitch expected %0d actual %0d",
                                 $time, e.pitch, got.pitch);
                        bad = bad + 1;
                    end
                    if (got.roll !== e.roll) begin
                        $display("%0t: roll expected %0d actual %0d",
                                 $time, e.roll, got.roll);
                        bad = bad + 1;
                    end
                end
            end
            errors <= errors + bad;
        end
    end

    assign pending = tilt_due.size();

endmodule

// File: test/tilt_complementary_filter_tb.sv
// Top of the tilt filter testbench: clock, reset, APB set-up, sample stimulus,
// result back-pressure and the verdict. Depends on tcf_pkg, both channel
// interfaces, tcf_checker and the tilt_complementary_filter RTL.
module tilt_complementary_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_WAIT  = 200;
    localparam int RANDOM_PER_PHASE = 260;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [tcf_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    int tx_idle_pct;
    int rx_idle_pct;
    logic long_hold_req;
    logic long_hold_done;
    int hold_left;
    int cycles;
    int errors;
    int pending;
    int beats_sent;
    logic [31:0] stamp;

    tcf_sample_if smp ();
    tcf_result_if res ();

    tilt_complementary_filter u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (smp),
        .result  (res)
    );

    tcf_checker u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .smp     (smp),
        .res     (res),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[tilt_complementary_filter] ERROR");
            $finish;
        end
    end

    // Result receiver: random stalls, plus one long hold-off so the output
    // register fills and the sequencer stops taking samples.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready      <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            hold_left      <= 3000;
            res.ready      <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // APB write with setup and access phases; the register takes the value on the
    // access edge, then the bus goes idle before the next transfer.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Drain all due results, let the block go idle, then load a new setting.
    task automatic load_setting(input logic [15:0] c, input logic [16:0] w,
                                input logic [31:0] g, input logic [19:0] d);
        smp.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        apb_write(tcf_pkg::REG_GYRO_CPD, {16'd0, c});
        apb_write(tcf_pkg::REG_BLEND_WEIGHT, {15'd0, w});
        apb_write(tcf_pkg::REG_MAX_GAP, g);
        apb_write(tcf_pkg::REG_DEFAULT_STEP, {12'd0, d});
    endtask

    // Offer one sample beat, with random sender gaps; hold valid high across
    // back-to-back beats so it is never lowered and raised in one step.
    task automatic push_sample(input logic rs, input logic [31:0] t,
                               input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [15:0] gx,
                               input logic [15:0] gy);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid   <= 1'b1;
        smp.restart <= rs;
        smp.time_us <= t;
        smp.accel_x <= ax;
        smp.accel_y <= ay;
        smp.accel_z <= az;
        smp.gyro_x  <= gx;
        smp.gyro_y  <= gy;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        beats_sent++;
        // idling follows progress through the random part
        if (beats_sent == 500)
        begin
            tx_idle_pct = 59;
            rx_idle_pct = 8;
        end
        else if (beats_sent == 1000)
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    function automatic logic [15:0] pick_axis();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return 16'($urandom());
        if (sel < 85)
            return 16'($signed($urandom_range(4000)) - 2000);
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'h0001;
        endcase
    endfunction

    // Mostly a steady sample stream with small steps; now and then a repeated
    // stamp, a huge jump, a wrap or a restart.
    task automatic random_stream(input int count);
        int sel;
        logic [31:0] step;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 80)
                step = $urandom_range(25000, 1);
            else if (sel < 86)
                step = 0;
            else if (sel < 93)
                step = $urandom();
            else
                step = $urandom_range(300000, 100);
            stamp = stamp + step;
            push_sample($urandom_range(99) < 4, stamp, pick_axis(), pick_axis(),
                        pick_axis(), pick_axis(), pick_axis());
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        smp.valid   = 1'b0;
        smp.restart = 1'b0;
        smp.time_us = '0;
        smp.accel_x = '0;
        smp.accel_y = '0;
        smp.accel_z = '0;
        smp.gyro_x  = '0;
        smp.gyro_y  = '0;
        cycles      = 0;
        beats_sent  = 0;
        stamp       = 0;
        tx_idle_pct = 8;
        rx_idle_pct = 59;
        long_hold_req = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset setting, zero vector seed, extremes, negative x,
        // repeated and oversized steps, timestamp wrap, restart.
        push_sample(0, 32'd100, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000);
        push_sample(0, 32'd100, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000);
        push_sample(0, 32'd5100, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        push_sample(0, 32'd9000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        push_sample(0, 32'd900000, 16'h4000, 16'h0000, 16'hc000, 16'h0010, 16'hfff0);
        push_sample(0, 32'hfffff000, 16'hc000, 16'hc000, 16'hc000, 16'h0000, 16'h0000);
        push_sample(0, 32'h00000800, 16'h0001, 16'h0001, 16'hffff, 16'hffff, 16'h0001);
        push_sample(1, 32'h00000900, 16'h8000, 16'h0000, 16'h7fff, 16'h1234, 16'h4321);
        push_sample(0, 32'h00001900, 16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h8000);
        push_sample(0, 32'h00002900, 16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h7fff);
        push_sample(0, 32'hffffffff, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        push_sample(1, 32'h00000000, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
        random_stream(RANDOM_PER_PHASE);

        // Smallest scale, pure accel weight, tightest gap, shortest default.
        load_setting(16'd1, 17'd0, 32'd1, 20'd1);
        push_sample(1, 32'd0, 16'h1000, 16'h2000, 16'h3000, 16'h7fff, 16'h8000);
        push_sample(0, 32'd1, 16'h1000, 16'h2000, 16'h3000, 16'h7fff, 16'h8000);
        push_sample(0, 32'd3, 16'h1000, 16'h2000, 16'h3000, 16'h7fff, 16'h8000);
        random_stream(RANDOM_PER_PHASE);

        // Largest values, full gyro weight; the long receiver hold-off is here.
        load_setting(16'hffff, 17'd65536, 32'hffffffff, 20'd1000000);
        long_hold_req = 1'b1;
        random_stream(RANDOM_PER_PHASE);

        // Zero gyro scale, weight above one, zero default step.
        load_setting(16'd0, 17'h1ffff, 32'd5000, 20'd0);
        push_sample(0, stamp, 16'h0100, 16'h0200, 16'h0300, 16'h7fff, 16'h8000);
        push_sample(0, stamp + 32'd10, 16'h0100, 16'h0200, 16'h0300, 16'h7fff, 16'h8000);
        stamp = stamp + 32'd10;
        random_stream(RANDOM_PER_PHASE);

        load_setting(16'd250, 17'd32768, 32'd30000, 20'd5000);
        random_stream(RANDOM_PER_PHASE);

        smp.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d samples over five register settings with sender and",
                 beats_sent);
        $display("receiver stalls, one long back-pressure stretch, restarts and bad steps.");
        if (errors == 0 && pending == 0)
            $display("[tilt_complementary_filter] OK");
        else
            $display("[tilt_complementary_filter] ERROR");
        $finish;
    end

endmodule
